// ----- sv/osf2_pkg.sv -----
// ============================================================================
// osf2_pkg - shared types and constants for the 2x2 observer with feedback
// Fixed-point formats, register indexes and saturation helpers.
// ============================================================================
package osf2_pkg;

    localparam int DATA_W         = 32;   // Q16.16 data word
    localparam int FRAC_BITS      = 16;   // fraction bits of data and gains
    localparam int COEF_FRAC_BITS = 30;   // fraction bits of dt-scaled coefs
    localparam int STEP_W         = 31;   // step_time register width
    localparam int PROD_W         = 2 * DATA_W;
    localparam int ACC_W          = 50;   // holds any sum formed in one tick
    localparam int CFG_ADDR_W     = 3;

    localparam logic signed [PROD_W-1:0] ROUND_DATA = PROD_W'(1) <<< (FRAC_BITS - 1);
    localparam logic signed [PROD_W-1:0] ROUND_COEF = PROD_W'(1) <<< (COEF_FRAC_BITS - 1);

    localparam logic signed [ACC_W-1:0] DATA_MAX =
        ACC_W'((64'sd1 <<< (DATA_W - 1)) - 64'sd1);
    localparam logic signed [ACC_W-1:0] DATA_MIN = -DATA_MAX - ACC_W'(1);

    // Register reset values
    localparam logic [STEP_W-1:0]        RST_STEP_TIME   = STEP_W'(1073742);
    localparam logic signed [DATA_W-1:0] RST_STIFF       = -32'sd2684355;
    localparam logic signed [DATA_W-1:0] RST_DAMP        = -32'sd429497;
    localparam logic signed [DATA_W-1:0] RST_INPUT       = 32'sd536871;
    localparam logic signed [DATA_W-1:0] RST_OBS_POS     = 32'sd30494268;
    localparam logic signed [DATA_W-1:0] RST_OBS_VEL     = 32'sd259995845;
    localparam logic signed [DATA_W-1:0] RST_FB_POS      = 32'sd1769472;
    localparam logic signed [DATA_W-1:0] RST_FB_VEL      = 32'sd891290;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_STEP_TIME   = 3'd0,
        REG_STIFF_DT    = 3'd1,
        REG_DAMP_DT     = 3'd2,
        REG_INPUT_DT    = 3'd3,
        REG_OBS_POS_DT  = 3'd4,
        REG_OBS_VEL_DT  = 3'd5,
        REG_FB_POS      = 3'd6,
        REG_FB_VEL      = 3'd7
    } cfg_reg_t;

    // Clamp a wide sum to the signed data range
    function automatic logic signed [DATA_W-1:0] sat_data(input logic signed [ACC_W-1:0] v);
        if (v > DATA_MAX) begin
            return DATA_MAX[DATA_W-1:0];
        end else if (v < DATA_MIN) begin
            return DATA_MIN[DATA_W-1:0];
        end
        return v[DATA_W-1:0];
    endfunction

    function automatic logic sat_hit(input logic signed [ACC_W-1:0] v);
        return (v > DATA_MAX) || (v < DATA_MIN);
    endfunction

endpackage

// ----- sv/observer_state_feedback_2x2.sv -----
// ============================================================================
// observer_state_feedback_2x2 - Luenberger observer with state feedback
// Second-order position/velocity estimator driving a saturated control effort.
// ============================================================================
// One input item is one control tick: measured and target position in Q16.16.
// The block returns one result item per tick: the drive
// u = -(fb_gain_pos*(est_pos-target) + fb_gain_vel*est_vel), the estimated
// position held before the tick, the innovation (measured minus estimated
// position) and a flag that is set when any sum hit the 32-bit limits. The
// estimate then takes one forward Euler step using the dt-scaled Q2.30
// coefficients. All eight products pass through one 32x32 signed multiplier
// under a small sequencer: it takes the item, forms the saturated position
// error and innovation, runs each of the eight products as a multiply step
// then a round-and-accumulate step, and posts the result once the output
// register is free; s_tready is low until the post. The next item is taken
// while the previous result still waits in the output register. Coefficients
// are written through the cfg_* port; the user must write them only while idle.
// ============================================================================
module observer_state_feedback_2x2
    import osf2_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    // Configuration write port
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [DATA_W-1:0]     cfg_wdata,
    // Input item channel
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [2*DATA_W-1:0]   s_tdata,   // measured_pos, target_pos
    // Result item channel
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [3*DATA_W-1:0]   m_tdata,   // drive, est_pos_out, innovation
    output logic                  m_tuser    // sat_flag
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_PREP,
        S_MUL,
        S_ACC,
        S_DONE
    } state_t;

    // Product schedule: feedback pair, position update pair, velocity update four
    typedef enum logic [2:0] {
        OP_FB_POS,
        OP_FB_VEL,
        OP_NP_VEL,
        OP_NP_INNOV,
        OP_NV_POS,
        OP_NV_VEL,
        OP_NV_DRIVE,
        OP_NV_INNOV
    } op_t;

    state_t state_reg;
    op_t    op_reg;

    // Configuration registers
    logic [STEP_W-1:0]        step_time_reg;
    logic signed [DATA_W-1:0] stiff_reg, damp_reg, input_reg;
    logic signed [DATA_W-1:0] obs_pos_reg, obs_vel_reg, fb_pos_reg, fb_vel_reg;

    // Observer state
    logic signed [DATA_W-1:0] est_pos_reg, est_vel_reg;

    // Per-tick working registers
    logic signed [DATA_W-1:0] meas_reg, targ_reg;
    logic signed [DATA_W-1:0] err_reg, innov_reg, drive_reg, np_reg, nv_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic                     flag_reg;

    // Output register
    logic                     m_tvalid_reg;
    logic [3*DATA_W-1:0]      m_tdata_reg;
    logic                     m_tuser_reg;

    // Shared multiplier operands
    logic signed [DATA_W-1:0] mul_a, mul_b;
    logic signed [PROD_W-1:0] rnd_sum;
    logic signed [ACC_W-1:0]  term, acc_base, acc_next, neg_next;
    logic signed [ACC_W-1:0]  err_diff, innov_diff;

    always_comb begin
        case (op_reg)
            OP_FB_POS:   begin mul_a = fb_pos_reg;  mul_b = err_reg;     end
            OP_FB_VEL:   begin mul_a = fb_vel_reg;  mul_b = est_vel_reg; end
            OP_NP_VEL:   begin mul_a = signed'({1'b0, step_time_reg}); mul_b = est_vel_reg; end
            OP_NP_INNOV: begin mul_a = obs_pos_reg; mul_b = innov_reg;   end
            OP_NV_POS:   begin mul_a = stiff_reg;   mul_b = est_pos_reg; end
            OP_NV_VEL:   begin mul_a = damp_reg;    mul_b = est_vel_reg; end
            OP_NV_DRIVE: begin mul_a = input_reg;   mul_b = drive_reg;   end
            OP_NV_INNOV: begin mul_a = obs_vel_reg; mul_b = innov_reg;   end
            default:     begin mul_a = '0;          mul_b = '0;          end
        endcase
    end

    // Round half up, then floor-shift to the data format
    always_comb begin
        if (op_reg == OP_FB_POS || op_reg == OP_FB_VEL) begin
            rnd_sum = prod_reg + ROUND_DATA;
            term    = ACC_W'(signed'(rnd_sum[PROD_W-1:FRAC_BITS]));
        end else begin
            rnd_sum = prod_reg + ROUND_COEF;
            term    = ACC_W'(signed'(rnd_sum[PROD_W-1:COEF_FRAC_BITS]));
        end
    end

    // Each sum opens with its state term, or with zero for the feedback
    always_comb begin
        case (op_reg)
            OP_FB_POS: acc_base = '0;
            OP_NP_VEL: acc_base = ACC_W'(est_pos_reg);
            OP_NV_POS: acc_base = ACC_W'(est_vel_reg);
            default:   acc_base = acc_reg;
        endcase
        acc_next = acc_base + term;
        neg_next = -acc_next;
    end

    assign err_diff   = ACC_W'(est_pos_reg) - ACC_W'(targ_reg);
    assign innov_diff = ACC_W'(meas_reg) - ACC_W'(est_pos_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            op_reg        <= OP_FB_POS;
            m_tvalid_reg  <= 1'b0;
            flag_reg      <= 1'b0;
            est_pos_reg   <= '0;
            est_vel_reg   <= '0;
            step_time_reg <= RST_STEP_TIME;
            stiff_reg     <= RST_STIFF;
            damp_reg      <= RST_DAMP;
            input_reg     <= RST_INPUT;
            obs_pos_reg   <= RST_OBS_POS;
            obs_vel_reg   <= RST_OBS_VEL;
            fb_pos_reg    <= RST_FB_POS;
            fb_vel_reg    <= RST_FB_VEL;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_reg_t'(cfg_addr))
                    REG_STEP_TIME:  step_time_reg <= cfg_wdata[STEP_W-1:0];
                    REG_STIFF_DT:   stiff_reg     <= cfg_wdata;
                    REG_DAMP_DT:    damp_reg      <= cfg_wdata;
                    REG_INPUT_DT:   input_reg     <= cfg_wdata;
                    REG_OBS_POS_DT: obs_pos_reg   <= cfg_wdata;
                    REG_OBS_VEL_DT: obs_vel_reg   <= cfg_wdata;
                    REG_FB_POS:     fb_pos_reg    <= cfg_wdata;
                    REG_FB_VEL:     fb_vel_reg    <= cfg_wdata;
                    default: ;
                endcase
            end

            // Post a new result from the final step, else drop the result
            // once the sink takes it
            if (state_reg == S_DONE && (!m_tvalid_reg || m_tready)) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE: begin
                    if (s_tvalid) begin
                        meas_reg  <= s_tdata[DATA_W-1:0];
                        targ_reg  <= s_tdata[2*DATA_W-1:DATA_W];
                        state_reg <= S_PREP;
                    end
                end
                S_PREP: begin
                    // Saturate error and innovation before they are multiplied
                    err_reg   <= sat_data(err_diff);
                    innov_reg <= sat_data(innov_diff);
                    flag_reg  <= sat_hit(err_diff) || sat_hit(innov_diff);
                    op_reg    <= OP_FB_POS;
                    state_reg <= S_MUL;
                end
                S_MUL: begin
                    prod_reg  <= mul_a * mul_b;
                    state_reg <= S_ACC;
                end
                S_ACC: begin
                    acc_reg <= acc_next;
                    case (op_reg)
                        OP_FB_VEL: begin
                            drive_reg <= sat_data(neg_next);
                            if (sat_hit(neg_next)) flag_reg <= 1'b1;
                        end
                        OP_NP_INNOV: begin
                            np_reg <= sat_data(acc_next);
                            if (sat_hit(acc_next)) flag_reg <= 1'b1;
                        end
                        OP_NV_INNOV: begin
                            nv_reg <= sat_data(acc_next);
                            if (sat_hit(acc_next)) flag_reg <= 1'b1;
                        end
                        default: ;
                    endcase
                    if (op_reg == OP_NV_INNOV) begin
                        state_reg <= S_DONE;
                    end else begin
                        op_reg    <= op_t'(op_reg + 3'd1);
                        state_reg <= S_MUL;
                    end
                end
                S_DONE: begin
                    // Hold until the output register is free, then post and advance
                    if (!m_tvalid_reg || m_tready) begin
                        m_tdata_reg  <= {innov_reg, est_pos_reg, drive_reg};
                        m_tuser_reg  <= flag_reg;
                        est_pos_reg  <= np_reg;
                        est_vel_reg  <= nv_reg;
                        state_reg    <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    a_accept_starts_tick: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (state_reg == S_PREP))
        else $error("accepted item did not start a tick");

    a_prep_starts_schedule: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_PREP) |=> (state_reg == S_MUL && op_reg == OP_FB_POS))
        else $error("product schedule did not start at the first product");

    a_result_from_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> $past(state_reg == S_DONE))
        else $error("result posted outside the final step");

    a_state_moves_at_post: assert property (@(posedge aclk) disable iff (!aresetn)
        ($past(aresetn) && (!$stable(est_pos_reg) || !$stable(est_vel_reg)))
            |-> ($past(state_reg == S_DONE) && m_tvalid_reg))
        else $error("estimate changed without a posted result");

endmodule
